>>> src/cluster_union_find_labeler_defines.svh
// assertion macros for the labeler
`ifndef CLUSTER_UNION_FIND_LABELER_DEFINES_SVH
`define CLUSTER_UNION_FIND_LABELER_DEFINES_SVH

// same-cycle implication
`define CUF_ASSERT_NOW(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define CUF_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

>>> src/cuf_pkg.sv
package cuf_pkg;

  localparam int unsigned SITES   = 1024;
  localparam int unsigned IDX_W   = $clog2(SITES);
  localparam int unsigned LBL_W   = IDX_W + 1;
  localparam int unsigned MAX_NBR = 8;
  localparam int unsigned NBR_W   = (MAX_NBR > 1) ? $clog2(MAX_NBR) : 1;
  localparam int unsigned NCNT_W  = NBR_W + 1;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned QDEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic {
    K_ADD  = 1'b0,
    K_READ = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NBR,
    S_LWAIT,
    S_WALK,
    S_UPD,
    S_OUT
  } back_state_e;

  typedef struct packed {
    kind_e                           kind;
    logic                            occupied;
    logic                            rd_ok;
    logic [IDX_W-1:0]                site;
    logic [MAX_NBR-1:0]              nbr_ok;
    logic [MAX_NBR-1:0][IDX_W-1:0]   nbr;
  } entry_t;

endpackage

>>> src/cluster_union_find_labeler.sv
// Connected-cluster labeler with union-find over two 1024-entry tables (parent links and
// site labels). Words are processed one at a time by the back end: an add of an occupied
// site links the site to itself, reads the label of each neighbor in use below the site,
// follows the parent links of each occupied neighbor to its root and then points each such
// root and the site's label at the smallest of those roots and the site; an empty add
// clears the label. A read looks up the label of a loaded site and follows the links to
// its root, and its word goes out through a register; while a word on the output is
// stalled, a further read word holds the back end until the first is taken. The single
// read port of the parent table sets the pace of every chain walk. A two-word queue lets
// the front take words while the back is busy; start and unused commands finish in the front.
module cluster_union_find_labeler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic                      occupied_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_0_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_1_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_2_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_3_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_4_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_5_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_6_i,
  input  logic [cuf_pkg::IDX_W-1:0] neighbor_7_i,
  input  logic [cuf_pkg::IDX_W-1:0] site_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cuf_pkg::IDX_W-1:0] read_site_o,
  output logic [cuf_pkg::LBL_W-1:0] root_label_o
);
  import cuf_pkg::*;

  logic [CFG_W-1:0]              nbr_use_q;
  logic [NCNT_W-1:0]             nbr_cnt;
  logic [MAX_NBR-1:0][IDX_W-1:0] nbr;
  logic                          push, full, pop, empty;
  entry_t                        push_data, pop_data;

  assign pready = 1'b1;
  assign prdata = {{(32-CFG_W){1'b0}}, nbr_use_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_use_q <= CFG_W'(4);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      nbr_use_q <= pwdata[CFG_W-1:0];
    end
  end

  assign nbr_cnt = (nbr_use_q > CFG_W'(MAX_NBR)) ? NCNT_W'(MAX_NBR) : NCNT_W'(nbr_use_q);

  assign nbr = {neighbor_7_i, neighbor_6_i, neighbor_5_i, neighbor_4_i,
                neighbor_3_i, neighbor_2_i, neighbor_1_i, neighbor_0_i};

  cuf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nbr_cnt_i    (nbr_cnt),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .occupied_i   (occupied_i),
    .nbr_i        (nbr),
    .site_index_i (site_index_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  cuf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  cuf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_site_o  (read_site_o),
    .root_label_o (root_label_o)
  );

endmodule

>>> src/cuf_queue.sv
module cuf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cuf_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cuf_pkg::entry_t pop_data_o
);
  import cuf_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  entry_t           mem_q [QDEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/cuf_front.sv
module cuf_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [cuf_pkg::NCNT_W-1:0]                nbr_cnt_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [1:0]                                cmd_i,
  input  logic                                      occupied_i,
  input  logic [cuf_pkg::MAX_NBR-1:0][cuf_pkg::IDX_W-1:0] nbr_i,
  input  logic [cuf_pkg::IDX_W-1:0]                 site_index_i,
  output logic                                      push_o,
  output cuf_pkg::entry_t                           push_data_o,
  input  logic                                      full_i
);
  import cuf_pkg::*;

  logic [LBL_W-1:0] loaded_q, loaded_d;
  logic             accept;
  logic             lat_full;
  logic [IDX_W-1:0] cur;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign lat_full   = (loaded_q >= LBL_W'(SITES));
  assign cur        = loaded_q[IDX_W-1:0];

  always_comb begin
    loaded_d    = loaded_q;
    push_o      = 1'b0;
    push_data_o = '0;
    push_data_o.nbr = nbr_i;
    for (int j = 0; j < MAX_NBR; j++) begin
      push_data_o.nbr_ok[j] = (NCNT_W'(j) < nbr_cnt_i) && (nbr_i[j] < cur);
    end
    push_data_o.occupied = occupied_i;
    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_START: loaded_d = '0;
        CMD_ADD: begin
          if (!lat_full) begin
            loaded_d         = loaded_q + 1'b1;
            push_o           = 1'b1;
            push_data_o.kind = K_ADD;
            push_data_o.site = cur;
          end
        end
        CMD_READ: begin
          push_o            = 1'b1;
          push_data_o.kind  = K_READ;
          push_data_o.site  = site_index_i;
          push_data_o.rd_ok = ({1'b0, site_index_i} < loaded_q);
        end
        default: loaded_d = loaded_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

endmodule

>>> src/cuf_back.sv
module cuf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  cuf_pkg::entry_t           entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cuf_pkg::IDX_W-1:0] read_site_o,
  output logic [cuf_pkg::LBL_W-1:0] root_label_o
);
  import cuf_pkg::*;

  logic [IDX_W-1:0] parent_mem [SITES];
  logic [LBL_W-1:0] label_mem  [SITES];

  back_state_e                 state_q, state_d;
  entry_t                      ent_q, ent_d;
  logic [NCNT_W-1:0]           j_q, j_d;
  logic [IDX_W-1:0]            k_q, k_d;
  logic [IDX_W-1:0]            mini_q, mini_d;
  logic [MAX_NBR-1:0][IDX_W-1:0] root_q, root_d;
  logic [MAX_NBR-1:0]          rv_q, rv_d;
  logic [LBL_W-1:0]            res_q, res_d;
  logic                        ov_q, ov_d;
  logic [IDX_W-1:0]            osite_q, osite_d;
  logic [LBL_W-1:0]            olbl_q, olbl_d;

  logic [IDX_W-1:0] l_raddr, p_raddr, l_waddr, p_waddr, p_wdata;
  logic [LBL_W-1:0] l_wdata, l_rd_q;
  logic [IDX_W-1:0] p_rd_q;
  logic             l_we, p_we;
  logic [NBR_W-1:0] jx;

  assign jx           = j_q[NBR_W-1:0];
  assign out_valid_o  = ov_q;
  assign read_site_o  = osite_q;
  assign root_label_o = olbl_q;

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    j_d     = j_q;
    k_d     = k_q;
    mini_d  = mini_q;
    root_d  = root_q;
    rv_d    = rv_q;
    res_d   = res_q;
    ov_d    = ov_q;
    osite_d = osite_q;
    olbl_d  = olbl_q;
    pop_o   = 1'b0;
    l_raddr = ent_q.site;
    p_raddr = k_q;
    l_we    = 1'b0;
    l_waddr = ent_q.site;
    l_wdata = '0;
    p_we    = 1'b0;
    p_waddr = ent_q.site;
    p_wdata = ent_q.site;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          ent_d = entry_i;
          if (entry_i.kind == K_READ) begin
            if (entry_i.rd_ok) begin
              l_raddr = entry_i.site;
              state_d = S_LWAIT;
            end else begin
              res_d   = '0;
              state_d = S_OUT;
            end
          end else if (!entry_i.occupied) begin
            l_we    = 1'b1;
            l_waddr = entry_i.site;
            l_wdata = '0;
          end else begin
            p_we    = 1'b1;
            p_waddr = entry_i.site;
            p_wdata = entry_i.site;
            mini_d  = entry_i.site;
            rv_d    = '0;
            j_d     = '0;
            state_d = S_NBR;
          end
        end
      end
      S_NBR: begin
        if (j_q == NCNT_W'(MAX_NBR)) begin
          j_d     = '0;
          state_d = S_UPD;
        end else if (ent_q.nbr_ok[jx]) begin
          l_raddr = ent_q.nbr[jx];
          state_d = S_LWAIT;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_LWAIT: begin
        if (l_rd_q == '0) begin
          if (ent_q.kind == K_READ) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_NBR;
          end
        end else begin
          k_d     = IDX_W'(l_rd_q - 1'b1);
          p_raddr = IDX_W'(l_rd_q - 1'b1);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (p_rd_q == k_q) begin
          if (ent_q.kind == K_READ) begin
            res_d   = {1'b0, k_q} + 1'b1;
            state_d = S_OUT;
          end else begin
            root_d[jx] = k_q;
            rv_d[jx]   = 1'b1;
            if (k_q < mini_q) begin
              mini_d = k_q;
            end
            j_d     = j_q + 1'b1;
            state_d = S_NBR;
          end
        end else begin
          k_d     = p_rd_q;
          p_raddr = p_rd_q;
        end
      end
      S_UPD: begin
        if (j_q == NCNT_W'(MAX_NBR)) begin
          l_we    = 1'b1;
          l_waddr = ent_q.site;
          l_wdata = {1'b0, mini_q} + 1'b1;
          state_d = S_IDLE;
        end else begin
          if (rv_q[jx] && (root_q[jx] != mini_q)) begin
            p_we    = 1'b1;
            p_waddr = root_q[jx];
            p_wdata = mini_q;
          end
          j_d = j_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          osite_d = ent_q.site;
          olbl_d  = res_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    k_q     <= k_d;
    mini_q  <= mini_d;
    root_q  <= root_d;
    rv_q    <= rv_d;
    res_q   <= res_d;
    osite_q <= osite_d;
    olbl_q  <= olbl_d;
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      label_mem[l_waddr] <= l_wdata;
    end
    l_rd_q <= label_mem[l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rd_q <= parent_mem[p_raddr];
  end

endmodule

>>> src/cuf_checker.sv
`include "cluster_union_find_labeler_defines.svh"

module cuf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [cuf_pkg::IDX_W-1:0] read_site_o,
  input logic [cuf_pkg::LBL_W-1:0] root_label_o,
  input logic [31:0]               prdata
);
  import cuf_pkg::*;

  logic [LBL_W-1:0] lbl_lim;

  // a root never lies above the site
  assign lbl_lim = {1'b0, read_site_o} + 1'b1;

  `CUF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `CUF_ASSERT_NOW(a_label_range, clk_i, rst_ni, out_valid_o, root_label_o <= lbl_lim)
  `CUF_ASSERT_NOW(a_prdata_range, clk_i, rst_ni, 1'b1, prdata[31:CFG_W] == '0)

endmodule

bind cluster_union_find_labeler cuf_checker u_cuf_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import cuf_pkg::*;

  localparam int unsigned N_SITES = 1024;
  localparam logic [2:0] REG_NBR_IN_USE = 3'd0;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic                          occupied;
    logic [7:0][IDX_W-1:0]         nbr;
    logic [IDX_W-1:0]              site_index;
  } word_t;

  typedef struct packed {
    logic [IDX_W-1:0] site;
    logic [LBL_W-1:0] label;
  } label_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  word_t cur = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IDX_W-1:0] read_site_o;
  logic [LBL_W-1:0] root_label_o;

  always #1 clk_i = ~clk_i;

  cluster_union_find_labeler dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .cmd_i(cur.cmd), .occupied_i(cur.occupied),
    .neighbor_0_i(cur.nbr[0]), .neighbor_1_i(cur.nbr[1]), .neighbor_2_i(cur.nbr[2]),
    .neighbor_3_i(cur.nbr[3]), .neighbor_4_i(cur.nbr[4]), .neighbor_5_i(cur.nbr[5]),
    .neighbor_6_i(cur.nbr[6]), .neighbor_7_i(cur.nbr[7]),
    .site_index_i(cur.site_index),
    .out_valid_o, .out_stall_i, .read_site_o, .root_label_o
  );

  // predictor state
  logic [IDX_W-1:0] link_tbl [N_SITES];
  logic [LBL_W-1:0] label_tbl [N_SITES];
  int unsigned loaded;
  int unsigned nbr_cfg;

  word_t pending_words[$];
  label_t expected_labels[$];
  int unsigned errors, n_words, n_reads, n_sent;
  bit in_idle_ok = 1'b1, out_idle_ok = 1'b1;
  bit hold_out = 1'b0;
  int in_gap, out_gap;

  function automatic int unsigned root_of(int unsigned k);
    int unsigned steps;
    steps = 0;
    while (k < N_SITES && link_tbl[k] != k && steps < N_SITES) begin
      k = link_tbl[k];
      steps++;
    end
    return k;
  endfunction

  function automatic void predict_word(word_t w);
    int unsigned i, cnt, mini, n, r;
    int unsigned roots[8];
    bit ok[8];
    label_t e;
    case (cmd_e'(w.cmd))
      CMD_START: loaded = 0;
      CMD_ADD: begin
        i = loaded;
        if (i < N_SITES) begin
          loaded = i + 1;
          if (!w.occupied) begin
            label_tbl[i] = '0;
          end else begin
            cnt = (nbr_cfg > 8) ? 8 : nbr_cfg;
            link_tbl[i] = IDX_W'(i);
            mini = i;
            for (int j = 0; j < 8; j++) begin
              n = w.nbr[j];
              ok[j] = 1'b0;
              roots[j] = 0;
              if (j < cnt && n < i && label_tbl[n] != 0) begin
                r = root_of(label_tbl[n] - 1);
                roots[j] = r;
                ok[j] = r < N_SITES;
                if (ok[j] && r < mini) mini = r;
              end
            end
            label_tbl[i] = LBL_W'(mini + 1);
            for (int j = 0; j < 8; j++)
              if (j < cnt && ok[j] && mini < link_tbl[roots[j]])
                link_tbl[roots[j]] = IDX_W'(mini);
          end
        end
      end
      CMD_READ: begin
        e.site = w.site_index;
        e.label = '0;
        if (w.site_index < loaded && label_tbl[w.site_index] != 0)
          e.label = LBL_W'(root_of(label_tbl[w.site_index] - 1) + 1);
        expected_labels.push_back(e);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) begin
          predict_word(cur);
          n_sent++;
        end
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          if (in_idle_ok && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    label_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_reads++;
        if (expected_labels.size() == 0) begin
          errors++;
          $display("%0t: unexpected word site %0d label %0d", $time, read_site_o,
                   root_label_o);
        end else begin
          e = expected_labels.pop_front();
          if (read_site_o !== e.site) begin
            errors++;
            $display("%0t: read_site exp %0d got %0d", $time, e.site, read_site_o);
          end
          if (root_label_o !== e.label) begin
            errors++;
            $display("%0t: root_label site %0d exp %0d got %0d", $time, e.site,
                     e.label, root_label_o);
          end
        end
      end
      if (hold_out) out_stall_i <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (out_idle_ok && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  task automatic write_nbr_cfg(int unsigned v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_NBR_IN_USE; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    nbr_cfg = v & 4'hF;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_labels.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic word_t site_word(bit occ, int unsigned base);
    word_t w;
    w = '0;
    w.cmd = CMD_ADD;
    w.occupied = occ;
    for (int j = 0; j < 8; j++) begin
      case ($urandom_range(0, 9))
        0: w.nbr[j] = IDX_W'($urandom());
        1: w.nbr[j] = IDX_W'(base + $urandom_range(0, 3));
        default: w.nbr[j] = IDX_W'((base > 0) ?
                                   base - $urandom_range(1, (base < 40) ? base : 40) : 0);
      endcase
    end
    w.site_index = IDX_W'($urandom());
    return w;
  endfunction

  function automatic word_t read_word(int unsigned hi);
    word_t w;
    w = '0;
    w.cmd = CMD_READ;
    w.nbr = (8*IDX_W)'({$urandom(), $urandom(), $urandom()});
    w.site_index = IDX_W'(($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, hi));
    return w;
  endfunction

  // fill a lattice of given size and read it back partly
  task automatic push_lattice(int unsigned sz, int unsigned reads);
    word_t w;
    w = '0;
    w.cmd = CMD_START;
    pending_words.push_back(w);
    for (int unsigned s = 0; s < sz; s++)
      pending_words.push_back(site_word($urandom_range(0, 3) != 0, s));
    for (int unsigned r = 0; r < reads; r++) begin
      if ($urandom_range(0, 15) == 0) begin
        w = '0;
        w.cmd = ($urandom_range(0, 1) != 0) ? CMD_NONE : CMD_ADD;
        w.occupied = 1'($urandom());
        w.nbr = (8*IDX_W)'({$urandom(), $urandom(), $urandom()});
        pending_words.push_back(w);
      end
      pending_words.push_back(read_word(sz));
    end
  endtask

  initial begin
    word_t w;
    errors = 0; n_sent = 0; n_reads = 0; loaded = 0; nbr_cfg = 4;
    in_gap = 0; out_gap = 0;
    for (int k = 0; k < N_SITES; k++) begin
      link_tbl[k] = '0;
      label_tbl[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: site 0 alone, chains, extremes
    w = '0; w.cmd = CMD_START; pending_words.push_back(w);
    w = '0; w.cmd = CMD_ADD; w.occupied = 1'b1; w.nbr = '1; pending_words.push_back(w);
    w = '0; w.cmd = CMD_ADD; w.occupied = 1'b0; pending_words.push_back(w);
    w = '0; w.cmd = CMD_ADD; w.occupied = 1'b1; w.nbr = '1; pending_words.push_back(w);
    w = '0; w.cmd = CMD_ADD; w.occupied = 1'b1; w.nbr[0] = 2; w.nbr[1] = 0;
    pending_words.push_back(w);
    w = '0; w.cmd = CMD_ADD; w.occupied = 1'b1; w.nbr[3] = 1; w.nbr[4] = 3;
    pending_words.push_back(w);
    w = '0; w.cmd = CMD_NONE; w.occupied = 1'b1; pending_words.push_back(w);
    for (int s = 0; s < 6; s++) begin
      w = '0; w.cmd = CMD_READ; w.site_index = IDX_W'(s); pending_words.push_back(w);
    end
    w = '0; w.cmd = CMD_READ; w.site_index = '1; pending_words.push_back(w);
    drain();

    write_nbr_cfg(8);
    push_lattice(24, 12);
    drain();
    write_nbr_cfg(0);
    push_lattice(12, 8);
    drain();
    write_nbr_cfg(15);
    push_lattice(20, 10);
    drain();

    // full lattice once, with adds past the end
    write_nbr_cfg(2);
    push_lattice(N_SITES + 3, 40);
    drain();

    // long receiver hold-off while the sender keeps going
    write_nbr_cfg(1);
    push_lattice(30, 20);
    hold_out = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_out = 1'b0;
    drain();

    for (int p = 0; p < 12; p++) begin
      write_nbr_cfg($urandom_range(1, 8));
      if (p >= 10) begin
        in_idle_ok = 1'b0;
        out_idle_ok = 1'b0;
      end
      push_lattice($urandom_range(4, 16), $urandom_range(4, 10));
      drain();
    end

    $display("sent %0d words through lattices of up to %0d sites; %0d labels checked",
             n_sent, N_SITES, n_reads);
    $display("neighbor counts 0 to 15 written, long output stall exercised");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/cuf_pkg.sv
src/cuf_queue.sv
src/cuf_front.sv
src/cuf_back.sv
src/cluster_union_find_labeler.sv
src/cuf_checker.sv
sim/tb.sv
